// ----- hw/rtl/csd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the cross stencil star detector.
// No dependencies; every other file refers to it by scoped names.
package csd_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;
    localparam int CNT_W   = 20;
    localparam int SUM_W   = PIX_W + 3;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int WCNT_W  = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
    localparam int HCNT_W  = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
    localparam int PROD_W  = ROW_W + WCNT_W;
    localparam int IDXC_W  = (PROD_W + 1 > CNT_W) ? PROD_W + 1 : CNT_W;
    localparam int WORD_W  = 2 * PIX_W;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_STAR_THRESHOLD = 2'd2;

    localparam int RST_FRAME_WIDTH  = 1024;
    localparam int RST_FRAME_HEIGHT = 1024;
    localparam logic [CFG_W-1:0] RST_STAR_THRESHOLD = 11'd30;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } t_lb_rd;

    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } t_lb_wr;

    function automatic logic [WCNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [WCNT_W-1:0] res;
        if (v == '0) begin
            res = WCNT_W'(1);
        end else if (int'(v) > MAX_COLS) begin
            res = WCNT_W'(MAX_COLS);
        end else begin
            res = WCNT_W'(v);
        end
        return res;
    endfunction

    function automatic logic [HCNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [HCNT_W-1:0] res;
        if (v == '0) begin
            res = HCNT_W'(1);
        end else if (int'(v) > MAX_ROWS) begin
            res = HCNT_W'(MAX_ROWS);
        end else begin
            res = HCNT_W'(v);
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/csd_line_buf.sv -----
`timescale 1ns / 1ps
// Line store for the detector: one word per column holding the row above and the
// row two above. Registered read with enable, one write port. Uses csd_pkg.
module csd_line_buf (
    input  logic                      i_clk,
    input  csd_pkg::t_lb_rd           i_rd,
    input  csd_pkg::t_lb_wr           i_wr,
    output logic [csd_pkg::WORD_W-1:0] o_rd_data
);

    logic [csd_pkg::WORD_W-1:0] r_mem [csd_pkg::MAX_COLS];
    logic [csd_pkg::WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/cross_stencil_star_detector.sv -----
`timescale 1ns / 1ps
// Top level of the five-point cross stencil star detector.
// Depends on csd_pkg and csd_line_buf.
//
// Usage:
// Pixels enter in raster order on i_pixel with i_in_valid; a request is taken at a
// clock edge where i_in_valid is high and o_in_stall is low. Every pixel gives
// exactly one result on the output channel, taken where o_out_valid is high and
// i_out_stall is low. A result reports whether the centre one row up was scored,
// whether it is a star, its linear index, the running star count, and a flag on
// the last pixel of the frame.
// A pixel passes through the scoring stage register, then the result register,
// where o_out_valid rises. One pixel is accepted per cycle while the receiver
// does not stall; the line store is read one column ahead so that every stencil
// operand is registered before scoring. While the receiver stalls, the result
// register holds and the scoring stage keeps one more pixel, then o_in_stall rises.
// Synchronous reset empties both stages and starts a new frame with width and
// height 1024 and threshold 30. The line store is not cleared; a frame writes
// each column before reading it. Writing the width or height starts a new frame.
// The user must write configuration only while the block is idle; no check enforces it.
module cross_stencil_star_detector (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [csd_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [csd_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [csd_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_center_valid,
    output logic                      o_is_star,
    output logic [csd_pkg::CNT_W-1:0] o_center_index,
    output logic [csd_pkg::CNT_W-1:0] o_star_count,
    output logic                      o_frame_done
);

    logic [csd_pkg::WCNT_W-1:0] r_width;
    logic [csd_pkg::HCNT_W-1:0] r_height;
    logic [csd_pkg::CFG_W-1:0]  r_thresh;

    logic [csd_pkg::COL_W-1:0]  r_col;
    logic [csd_pkg::ROW_W-1:0]  r_row;
    logic [csd_pkg::COL_W-1:0]  n_col;
    logic [csd_pkg::ROW_W-1:0]  n_row;

    logic                        r_s1_vld;
    logic [csd_pkg::PIX_W-1:0]  r_s1_px;
    logic [csd_pkg::COL_W-1:0]  r_s1_col;
    logic [csd_pkg::ROW_W-1:0]  r_s1_row;
    logic                        r_s1_done;
    logic [csd_pkg::WORD_W-1:0] r_cur;
    logic [csd_pkg::PIX_W-1:0]  r_left;
    logic [csd_pkg::WORD_W-1:0] rd_word;

    logic [csd_pkg::CNT_W-1:0]  r_count;
    logic [csd_pkg::CNT_W-1:0]  n_count;

    logic                        r_out_vld;
    logic                        r_out_cv;
    logic                        r_out_star;
    logic [csd_pkg::CNT_W-1:0]  r_out_idx;
    logic [csd_pkg::CNT_W-1:0]  r_out_cnt;
    logic                        r_out_done;

    logic                        in_acc;
    logic                        s1_adv;
    logic                        geom_wr;
    logic [csd_pkg::WCNT_W-1:0] col_p1;
    logic [csd_pkg::HCNT_W-1:0] row_p1;
    logic                        col_last;
    logic                        in_done;

    logic [csd_pkg::WCNT_W-1:0] s1_col_p1;
    logic                        s1_cv;
    logic [csd_pkg::SUM_W-1:0]  s1_sum;
    logic                        s1_star;
    logic [csd_pkg::PROD_W-1:0] s1_prod;
    logic [csd_pkg::IDXC_W-1:0] s1_idx_full;
    logic [csd_pkg::CNT_W-1:0]  s1_idx;

    csd_pkg::t_lb_rd lb_rd;
    csd_pkg::t_lb_wr lb_wr;

    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign geom_wr    = i_cfg_we && (i_cfg_idx == csd_pkg::REG_FRAME_WIDTH ||
                                     i_cfg_idx == csd_pkg::REG_FRAME_HEIGHT);

    // Input-side position tracking.
    assign col_p1   = csd_pkg::WCNT_W'(r_col) + csd_pkg::WCNT_W'(1);
    assign row_p1   = csd_pkg::HCNT_W'(r_row) + csd_pkg::HCNT_W'(1);
    assign col_last = (col_p1 == r_width);
    assign in_done  = col_last && (row_p1 == r_height);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (in_done) begin
                n_col = '0;
                n_row = '0;
            end else if (col_last) begin
                n_col = '0;
                n_row = csd_pkg::ROW_W'(row_p1);
            end else begin
                n_col = csd_pkg::COL_W'(col_p1);
            end
        end
    end

    // The store is read one column ahead of the accepted pixel.
    assign lb_rd.en   = in_acc;
    assign lb_rd.addr = n_col;

    assign lb_wr.en   = s1_adv;
    assign lb_wr.addr = r_s1_col;
    assign lb_wr.data = {r_s1_px, r_cur[csd_pkg::WORD_W-1:csd_pkg::PIX_W]};

    csd_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd      (lb_rd),
        .i_wr      (lb_wr),
        .o_rd_data (rd_word)
    );

    // Scoring stage: centre and up from r_cur, right from the prefetched word,
    // left from the previous centre, down is the arriving pixel.
    assign s1_col_p1 = csd_pkg::WCNT_W'(r_s1_col) + csd_pkg::WCNT_W'(1);
    assign s1_cv     = (r_s1_row >= csd_pkg::ROW_W'(2)) && (r_s1_col != '0) &&
                       (s1_col_p1 < r_width);
    assign s1_sum    = csd_pkg::SUM_W'(r_cur[csd_pkg::WORD_W-1:csd_pkg::PIX_W])
                     + csd_pkg::SUM_W'(r_cur[csd_pkg::PIX_W-1:0])
                     + csd_pkg::SUM_W'(rd_word[csd_pkg::WORD_W-1:csd_pkg::PIX_W])
                     + csd_pkg::SUM_W'(r_left)
                     + csd_pkg::SUM_W'(r_s1_px);
    assign s1_star   = s1_cv && (s1_sum > r_thresh);
    assign s1_prod   = csd_pkg::PROD_W'(r_s1_row - csd_pkg::ROW_W'(1))
                     * csd_pkg::PROD_W'(r_width);
    assign s1_idx_full = csd_pkg::IDXC_W'(s1_prod) + csd_pkg::IDXC_W'(r_s1_col);
    assign s1_idx    = s1_cv ? s1_idx_full[csd_pkg::CNT_W-1:0] : '0;

    always_comb begin
        n_count = r_count;
        if (s1_star && r_count != csd_pkg::CNT_MAX) begin
            n_count = r_count + csd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= csd_pkg::clamp_cols(csd_pkg::CFG_W'(csd_pkg::RST_FRAME_WIDTH));
            r_height  <= csd_pkg::clamp_rows(csd_pkg::CFG_W'(csd_pkg::RST_FRAME_HEIGHT));
            r_thresh  <= csd_pkg::RST_STAR_THRESHOLD;
            r_col     <= '0;
            r_row     <= '0;
            r_s1_vld  <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == csd_pkg::REG_FRAME_WIDTH) begin
                r_width <= csd_pkg::clamp_cols(i_cfg_wdata);
            end
            if (i_cfg_we && i_cfg_idx == csd_pkg::REG_FRAME_HEIGHT) begin
                r_height <= csd_pkg::clamp_rows(i_cfg_wdata);
            end
            if (i_cfg_we && i_cfg_idx == csd_pkg::REG_STAR_THRESHOLD) begin
                r_thresh <= i_cfg_wdata;
            end

            if (geom_wr) begin
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end

            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end

            if (geom_wr) begin
                r_count <= '0;
            end else if (s1_adv) begin
                r_count <= r_s1_done ? '0 : n_count;
            end

            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px   <= i_pixel;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_done <= in_done;
        end
        if (s1_adv) begin
            r_cur      <= rd_word;
            r_left     <= r_cur[csd_pkg::WORD_W-1:csd_pkg::PIX_W];
            r_out_cv   <= s1_cv;
            r_out_star <= s1_star;
            r_out_idx  <= s1_idx;
            r_out_cnt  <= n_count;
            r_out_done <= r_s1_done;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_center_valid = r_out_cv;
    assign o_is_star      = r_out_star;
    assign o_center_index = r_out_idx;
    assign o_star_count   = r_out_cnt;
    assign o_frame_done   = r_out_done;

    a_star_needs_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_star |-> r_out_cv)
        else $error("star flagged without an evaluated centre");

    a_no_centre_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_cv |-> r_out_idx == '0)
        else $error("centre index nonzero without a centre");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted pixel lost before scoring stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |=> r_s1_vld && $stable(r_s1_col) && $stable(r_s1_px))
        else $error("scoring stage changed while blocked");

    a_count_on_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && s1_star && !r_s1_done && r_count != csd_pkg::CNT_MAX |=>
            r_count == $past(r_count) + csd_pkg::CNT_W'(1))
        else $error("star count did not advance on a star");

endmodule

// ----- sim/star_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the cross stencil star detector: tracks register writes and accepted
// pixel requests, predicts each result and compares it with the output channel.
// Depends on csd_pkg for widths, register indexes and limits.
module star_result_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [csd_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [csd_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [csd_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_center_valid,
    input  logic                      i_is_star,
    input  logic [csd_pkg::CNT_W-1:0] i_center_index,
    input  logic [csd_pkg::CNT_W-1:0] i_star_count,
    input  logic                      i_frame_done,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic                      center_valid;
        logic                      is_star;
        logic [csd_pkg::CNT_W-1:0] center_index;
        logic [csd_pkg::CNT_W-1:0] star_count;
        logic                      frame_done;
    } t_star_result;

    logic [csd_pkg::CFG_W-1:0] frame_width;
    logic [csd_pkg::CFG_W-1:0] frame_height;
    logic [csd_pkg::CFG_W-1:0] star_threshold;
    logic [csd_pkg::PIX_W-1:0] line_above [csd_pkg::MAX_COLS];
    logic [csd_pkg::PIX_W-1:0] line_two_above [csd_pkg::MAX_COLS];
    int unsigned               col;
    int unsigned               row;
    logic [csd_pkg::CNT_W-1:0] stars;

    t_star_result     expected_results [$];
    t_star_result     oldest;
    int               mismatches = 0;
    int unsigned      results_seen = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what);
        $display("result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [csd_pkg::CNT_W-1:0] got,
                               input logic [csd_pkg::CNT_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
        end
    endtask

    function automatic t_star_result score_pixel(input logic [csd_pkg::PIX_W-1:0] px);
        t_star_result res;
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        int unsigned  sum;
        w = (frame_width == '0) ? 1 :
            ((frame_width > csd_pkg::MAX_COLS) ? csd_pkg::MAX_COLS : frame_width);
        h = (frame_height == '0) ? 1 :
            ((frame_height > csd_pkg::MAX_ROWS) ? csd_pkg::MAX_ROWS : frame_height);
        c = (col >= w) ? 0 : col;
        r = (row >= h) ? 0 : row;
        res = '0;
        if (r >= 2 && c >= 1 && c + 1 < w) begin
            sum = line_above[c] + line_two_above[c - 1] + line_above[c + 1]
                + line_two_above[c] + px;
            res.center_valid = 1'b1;
            res.center_index = csd_pkg::CNT_W'((r - 1) * w + c);
            if (sum > star_threshold) begin
                res.is_star = 1'b1;
                if (stars != csd_pkg::CNT_MAX) begin
                    stars++;
                end
            end
        end
        line_two_above[c] = line_above[c];
        line_above[c] = px;
        res.star_count = stars;
        res.frame_done = (c + 1 == w) && (r + 1 == h);
        if (res.frame_done) begin
            col = 0;
            row = 0;
            stars = '0;
        end else if (c + 1 == w) begin
            col = 0;
            row = r + 1;
        end else begin
            col = c + 1;
            row = r;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_width = csd_pkg::CFG_W'(csd_pkg::RST_FRAME_WIDTH);
            frame_height = csd_pkg::CFG_W'(csd_pkg::RST_FRAME_HEIGHT);
            star_threshold = csd_pkg::RST_STAR_THRESHOLD;
            col = 0;
            row = 0;
            stars = '0;
            for (int i = 0; i < csd_pkg::MAX_COLS; i++) begin
                line_above[i] = '0;
                line_two_above[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result arrived with no pixel request outstanding");
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("center_valid", csd_pkg::CNT_W'(i_center_valid),
                                csd_pkg::CNT_W'(oldest.center_valid));
                    check_field("is_star", csd_pkg::CNT_W'(i_is_star),
                                csd_pkg::CNT_W'(oldest.is_star));
                    check_field("center_index", i_center_index, oldest.center_index);
                    check_field("star_count", i_star_count, oldest.star_count);
                    check_field("frame_done", csd_pkg::CNT_W'(i_frame_done),
                                csd_pkg::CNT_W'(oldest.frame_done));
                end
                results_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csd_pkg::REG_FRAME_WIDTH: begin
                        frame_width = i_cfg_wdata;
                        col = 0;
                        row = 0;
                        stars = '0;
                    end
                    csd_pkg::REG_FRAME_HEIGHT: begin
                        frame_height = i_cfg_wdata;
                        col = 0;
                        row = 0;
                        stars = '0;
                    end
                    csd_pkg::REG_STAR_THRESHOLD: begin
                        star_threshold = i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(score_pixel(i_pixel));
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- sim/cross_stencil_star_detector_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the cross stencil star detector: drives registers and pixel requests
// under varying idle patterns and gives the verdict from star_result_checker.
// Depends on csd_pkg, cross_stencil_star_detector and star_result_checker.
module cross_stencil_star_detector_test;

    localparam logic [csd_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {PIX_FULL, PIX_DIM, PIX_BINARY} t_pixel_mix;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [csd_pkg::IDX_W-1:0] i_cfg_idx = '0;
    logic [csd_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [csd_pkg::PIX_W-1:0] i_pixel = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_center_valid;
    logic                      o_is_star;
    logic [csd_pkg::CNT_W-1:0] o_center_index;
    logic [csd_pkg::CNT_W-1:0] o_star_count;
    logic                      o_frame_done;

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               fail_count;
    int               pending;

    cross_stencil_star_detector uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_center_valid (o_center_valid),
        .o_is_star      (o_is_star),
        .o_center_index (o_center_index),
        .o_star_count   (o_star_count),
        .o_frame_done   (o_frame_done)
    );

    star_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_pixel        (i_pixel),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_center_valid (o_center_valid),
        .i_is_star      (o_is_star),
        .i_center_index (o_center_index),
        .i_star_count   (o_star_count),
        .i_frame_done   (o_frame_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic int eff_size(input logic [csd_pkg::CFG_W-1:0] v, input int limit);
        return (v == '0) ? 1 : ((v > limit) ? limit : int'(v));
    endfunction

    function automatic logic [csd_pkg::PIX_W-1:0] make_pixel(input t_pixel_mix mix);
        case (mix)
            PIX_DIM:    return csd_pkg::PIX_W'($urandom_range(20));
            PIX_BINARY: return ($urandom_range(1) != 0) ? '1 : '0;
            default:    return csd_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Returns once every outstanding request has produced its result and the block is quiet.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [csd_pkg::IDX_W-1:0] idx,
                             input logic [csd_pkg::CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic [csd_pkg::PIX_W-1:0] px);
        if ($urandom_range(199) == 0) begin
            wait_drained();
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_frame(input logic [csd_pkg::CFG_W-1:0] w,
                             input logic [csd_pkg::CFG_W-1:0] h,
                             input logic [csd_pkg::CFG_W-1:0] thr, input int count,
                             input t_pixel_mix mix);
        int split;
        wait_drained();
        write_reg(csd_pkg::REG_FRAME_WIDTH, w);
        write_reg(csd_pkg::REG_FRAME_HEIGHT, h);
        write_reg(csd_pkg::REG_STAR_THRESHOLD, thr);
        i_cfg_we <= 1'b0;
        split = ($urandom_range(9) == 0) ? int'($urandom_range(count)) : -1;
        for (int i = 0; i < count; i++) begin
            if (i == split) begin
                wait_drained();
                write_reg(($urandom_range(1) != 0) ? csd_pkg::REG_STAR_THRESHOLD : REG_UNUSED,
                          csd_pkg::CFG_W'($urandom_range(2047)));
                i_cfg_we <= 1'b0;
            end
            push_pixel(make_pixel(mix));
        end
    endtask

    task automatic random_phase(input int quota);
        int                        sent;
        int                        count;
        logic [csd_pkg::CFG_W-1:0] w;
        logic [csd_pkg::CFG_W-1:0] h;
        logic [csd_pkg::CFG_W-1:0] thr;
        sent = 0;
        while (sent < quota) begin
            w = ($urandom_range(4) != 0) ? csd_pkg::CFG_W'($urandom_range(12, 3))
                                         : csd_pkg::CFG_W'($urandom_range(2, 0));
            h = ($urandom_range(4) != 0) ? csd_pkg::CFG_W'($urandom_range(8, 3))
                                         : csd_pkg::CFG_W'($urandom_range(2, 0));
            count = eff_size(w, csd_pkg::MAX_COLS) * eff_size(h, csd_pkg::MAX_ROWS);
            case ($urandom_range(24))
                0: begin
                    w = csd_pkg::CFG_W'($urandom_range(2047, 1025));
                    count = int'($urandom_range(60, 1));
                end
                1: begin
                    h = csd_pkg::CFG_W'($urandom_range(2047, 1025));
                    count = int'($urandom_range(60, 1));
                end
                2, 3, 4: count = int'($urandom_range(count, 1));
                default: begin
                end
            endcase
            case ($urandom_range(4))
                0, 1, 2: thr = csd_pkg::CFG_W'($urandom_range(400));
                3:       thr = csd_pkg::CFG_W'($urandom_range(2047));
                default: thr = ($urandom_range(1) != 0) ? '1 : '0;
            endcase
            run_frame(w, h, thr, count, t_pixel_mix'($urandom_range(2)));
            sent += count;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 21;
        recv_idle_pct = 86;

        // A few pixels in the reset geometry, then a 3x3 frame whose only centre
        // sums to exactly the threshold, then one that clears it by one.
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd128);
        wait_drained();
        write_reg(csd_pkg::REG_FRAME_WIDTH, 11'd3);
        write_reg(csd_pkg::REG_FRAME_HEIGHT, 11'd3);
        write_reg(csd_pkg::REG_STAR_THRESHOLD, 11'd0);
        i_cfg_we <= 1'b0;
        repeat (9) push_pixel(8'd0);
        wait_drained();
        write_reg(csd_pkg::REG_STAR_THRESHOLD, 11'd1274);
        i_cfg_we <= 1'b0;
        repeat (9) push_pixel(8'd255);
        // Zero geometry clamps to a single pixel frame.
        wait_drained();
        write_reg(csd_pkg::REG_FRAME_WIDTH, 11'd0);
        write_reg(csd_pkg::REG_FRAME_HEIGHT, 11'd0);
        i_cfg_we <= 1'b0;
        push_pixel(8'd255);
        push_pixel(8'd0);

        run_frame(11'd1024, 11'd1024, 11'd30, 40, PIX_DIM);
        random_phase(150);

        send_idle_pct = 86;
        recv_idle_pct = 21;
        run_frame(11'd0, 11'd2047, 11'd2047, 200, PIX_FULL);
        random_phase(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_frame(11'd2047, 11'd3, 11'd600, 200, PIX_FULL);
        random_phase(150);

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/csd_pkg.sv
hw/rtl/csd_line_buf.sv
hw/rtl/cross_stencil_star_detector.sv
sim/star_result_checker.sv
sim/cross_stencil_star_detector_test.sv
